### sv/abv_pkg.sv
package abv_pkg;

    // Display modes
    localparam logic [1:0] MODE_NORMAL      = 2'd0;
    localparam logic [1:0] MODE_RED         = 2'd1;
    localparam logic [1:0] MODE_INVERSE     = 2'd2;
    localparam logic [1:0] MODE_INVERSE_RED = 2'd3;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Escape sequence bytes
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] SEQ_END  = 8'h6D;  // 'm' closes every sequence

    // One classified word: mapped character and whether a mode switch precedes it
    typedef struct packed {
        logic       emit;
        logic [1:0] mode;
        logic [7:0] ch;
    } t_op;

    // Front to queue
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### sv/abv_if.sv
interface abv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface abv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

### sv/abv_front.sv
module abv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    abv_in_if.sink               i_in,
    input  abv_pkg::t_qstat      i_qstat,
    output abv_pkg::t_push       o_push
);

    logic [1:0] r_mode;
    logic [1:0] n_mode;
    logic [1:0] cls_mode;
    logic [7:0] cls_ch;
    logic       accept;

    // Sort the byte into a mode and map it to a printable character
    always_comb begin
        case (i_in.in_byte) inside
            [8'h00:8'h1F]: begin
                cls_mode = abv_pkg::MODE_RED;
                cls_ch   = i_in.in_byte + 8'h40;
            end
            [8'h20:8'h7E]: begin
                cls_mode = abv_pkg::MODE_NORMAL;
                cls_ch   = i_in.in_byte;
            end
            8'h7F: begin
                cls_mode = abv_pkg::MODE_RED;
                cls_ch   = 8'h3F;
            end
            [8'h80:8'h9F]: begin
                cls_mode = abv_pkg::MODE_INVERSE_RED;
                cls_ch   = i_in.in_byte - 8'h40;
            end
            [8'hA0:8'hFE]: begin
                cls_mode = abv_pkg::MODE_INVERSE;
                cls_ch   = {1'b0, i_in.in_byte[6:0]};
            end
            default: begin
                cls_mode = abv_pkg::MODE_INVERSE_RED;
                cls_ch   = 8'h3F;
            end
        endcase
    end

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && !i_qstat.full;

    // Push the classified word; flag a switch when the mode changes
    always_comb begin
        o_push.valid   = accept;
        o_push.op.emit = (cls_mode != r_mode);
        o_push.op.mode = cls_mode;
        o_push.op.ch   = cls_ch;
    end

    // Track the terminal mode; drop back to normal at end of string
    always_comb begin
        n_mode = r_mode;
        if (accept) begin
            n_mode = i_in.end_of_string ? abv_pkg::MODE_NORMAL : cls_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= abv_pkg::MODE_NORMAL;
        end else begin
            r_mode <= n_mode;
        end
    end

endmodule

### sv/abv_queue.sv
module abv_queue #(
    parameter int DEPTH = abv_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abv_pkg::t_push  i_push,
    input  logic            i_pop,
    output abv_pkg::t_op    o_head,
    output abv_pkg::t_qstat o_qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    abv_pkg::t_op   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_count == CNT_FULL);
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push.valid && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rptr];

    // Store words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### sv/abv_back.sv
module abv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abv_pkg::t_op    i_head,
    input  abv_pkg::t_qstat i_qstat,
    output logic            o_pop,
    abv_out_if.source       o_out
);

    // Length of the escape sequence for a mode
    function automatic logic [2:0] seq_len(input logic [1:0] mode);
        logic [2:0] len;
        case (mode)
            abv_pkg::MODE_NORMAL:  len = 3'd4;
            abv_pkg::MODE_RED:     len = 3'd7;
            abv_pkg::MODE_INVERSE: len = 3'd6;
            default:               len = 3'd7;
        endcase
        return len;
    endfunction

    // Byte at position idx of the escape sequence for a mode
    function automatic logic [7:0] seq_byte(input logic [1:0] mode, input logic [2:0] idx);
        logic [7:0] b;
        b = abv_pkg::SEQ_END;
        case (idx)
            3'd0: b = abv_pkg::ESC_BYTE;
            3'd1: b = 8'h5B;                                           // '['
            3'd2: b = (mode == abv_pkg::MODE_INVERSE_RED) ? 8'h33 : 8'h30;
            3'd3: begin
                case (mode)
                    abv_pkg::MODE_NORMAL:      b = abv_pkg::SEQ_END;
                    abv_pkg::MODE_INVERSE_RED: b = 8'h31;
                    default:                   b = 8'h3B;          // ';'
                endcase
            end
            3'd4: begin
                case (mode)
                    abv_pkg::MODE_RED:         b = 8'h33;
                    abv_pkg::MODE_INVERSE:     b = 8'h37;
                    default:                   b = 8'h3B;
                endcase
            end
            3'd5: begin
                case (mode)
                    abv_pkg::MODE_RED:         b = 8'h31;
                    abv_pkg::MODE_INVERSE:     b = abv_pkg::SEQ_END;
                    default:                   b = 8'h37;
                endcase
            end
            default: b = abv_pkg::SEQ_END;
        endcase
        return b;
    endfunction

    logic         r_busy;
    abv_pkg::t_op r_op;
    logic [2:0]   r_idx;
    logic         r_out_valid;
    logic [7:0]   r_out_char;
    logic         r_out_last;

    abv_pkg::t_op cur;
    logic [2:0]   cur_idx;
    logic         seq_done;
    logic         out_free;
    logic         step;

    // Work on the held word, else straight from the queue head
    assign cur      = r_busy ? r_op : i_head;
    assign cur_idx  = r_busy ? r_idx : 3'd0;
    assign seq_done = !cur.emit || (cur_idx == seq_len(cur.mode));
    assign out_free = !r_out_valid || o_out.ready;
    assign step     = out_free && (r_busy || !i_qstat.empty);
    assign o_pop    = step && !r_busy;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.last_of_run = r_out_last;

    // Hold the word under work and its sequence position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (step) begin
            r_busy <= !seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_op  <= cur;
            r_idx <= cur_idx + 3'd1;
        end
    end

    // Output register: one byte per cycle while the sink takes them and a word is held or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_char <= seq_done ? cur.ch : seq_byte(cur.mode, cur_idx);
            r_out_last <= seq_done;
        end
    end

endmodule

### sv/ansi_byte_visualizer.sv
// Channel  Dir  Word                       Handshake
// i_in     in   in_byte[8], end_of_string  valid/ready
// o_out    out  out_char[8], last_of_run   valid/ready
//
// A word leaves as 1 to 8 bytes (escape sequence, then the mapped character);
// the back sequencer emits one byte per cycle while the sink takes them and a
// word is held or queued.
// Input words are taken every cycle while the queue (DEPTH words) has room.
// Synchronous active-low reset returns the mode to normal and empties the queue.
// A stalled output holds its byte; the front keeps filling the queue meanwhile.
module ansi_byte_visualizer #(
    parameter int DEPTH = abv_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    abv_in_if.sink     i_in,
    abv_out_if.source  o_out
);

    abv_pkg::t_push  push;
    abv_pkg::t_op    head;
    abv_pkg::t_qstat qstat;
    logic            pop;

    abv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push)
    );

    abv_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    abv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // Track the previous delivered byte for the checks below
    logic       r_prev_last;
    logic [7:0] r_prev_char;
    logic       out_acc;

    assign out_acc = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
        end else if (out_acc) begin
            r_prev_last <= o_out.last_of_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_char <= o_out.out_char;
        end
    end

    // A sequence opens with ESC
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_out.last_of_run && r_prev_last |-> o_out.out_char == abv_pkg::ESC_BYTE)
        else $error("escape sequence does not start with ESC");

    // A sequence closes with 'm' right before its character
    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out.last_of_run && !r_prev_last |-> r_prev_char == abv_pkg::SEQ_END)
        else $error("escape sequence does not end with m");

    // A push is only raised while the queue has room
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> i_in.ready && !qstat.full)
        else $error("push into a full queue");

endmodule
